// ===== rtl/lps_pkg.sv =====
// Shared types and constants for the landing phase sequencer.
package lps_pkg;

    // Field widths
    localparam int CodeW    = 2;
    localparam int OffsetW  = 16;
    localparam int HeightW  = 18;
    localparam int ElapsedW = 16;
    localparam int PhaseW   = 4;
    localparam int CountW   = 16;
    localparam int TimerW   = 25;
    localparam int RadiusW  = 15;
    localparam int RadSqW   = 2 * RadiusW;
    localparam int HoldW    = 24;
    localparam int ErrSqW   = 32;

    // Stream and config port widths
    localparam int InDataW  = 72;
    localparam int OutDataW = 8;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 24;

    localparam logic [CountW-1:0] CountMax = '1;
    localparam logic [TimerW-1:0] TimerMax = '1;

    // Failsafe codes
    localparam logic [CodeW-1:0] FS_NONE   = 2'd0;
    localparam logic [CodeW-1:0] FS_LOST   = 2'd1;
    localparam logic [CodeW-1:0] FS_STALE  = 2'd2;
    localparam logic [CodeW-1:0] FS_CRIT   = 2'd3;

    // Config register indexes
    localparam logic [CfgIdxW-1:0] REG_ACQUIRE_FRAMES = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ALIGN_RADIUS   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_HOLD_TIME      = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_DESCEND_ALT    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_LAND_ALT       = 3'd4;

    // Phase codes as seen on the output
    localparam logic [PhaseW-1:0] PH_INIT     = 4'd0;
    localparam logic [PhaseW-1:0] PH_SEARCH   = 4'd1;
    localparam logic [PhaseW-1:0] PH_ACQUIRE  = 4'd2;
    localparam logic [PhaseW-1:0] PH_ALIGN    = 4'd3;
    localparam logic [PhaseW-1:0] PH_HOLD     = 4'd4;
    localparam logic [PhaseW-1:0] PH_DESCEND  = 4'd5;
    localparam logic [PhaseW-1:0] PH_FINAL    = 4'd6;
    localparam logic [PhaseW-1:0] PH_LAND     = 4'd7;
    localparam logic [PhaseW-1:0] PH_FAILSAFE = 4'd8;

    // Phase state, one-hot
    typedef enum logic [8:0] {
        ST_INIT     = 9'b0_0000_0001,
        ST_SEARCH   = 9'b0_0000_0010,
        ST_ACQUIRE  = 9'b0_0000_0100,
        ST_ALIGN    = 9'b0_0000_1000,
        ST_HOLD     = 9'b0_0001_0000,
        ST_DESCEND  = 9'b0_0010_0000,
        ST_FINAL    = 9'b0_0100_0000,
        ST_LAND     = 9'b0_1000_0000,
        ST_FAILSAFE = 9'b1_0000_0000
    } phase_t;

    // One observation
    typedef struct packed {
        logic        [CodeW-1:0]    failsafe_code;
        logic signed [OffsetW-1:0]  offset_x;
        logic signed [OffsetW-1:0]  offset_y;
        logic signed [HeightW-1:0]  height_mm;
        logic        [ElapsedW-1:0] elapsed_us;
    } item_t;

    // Sequencer state
    typedef struct packed {
        phase_t              phase;
        logic [TimerW-1:0]   hold_timer;
        logic [CountW-1:0]   frame_count;
    } seq_state_t;

    // Configuration as used by the step logic
    typedef struct packed {
        logic        [CountW-1:0]  acquire_frames;
        logic        [RadSqW-1:0]  radius_sq;
        logic        [HoldW-1:0]   hold_time_us;
        logic signed [HeightW-1:0] descend_alt_mm;
        logic signed [HeightW-1:0] land_alt_mm;
    } cfg_t;

    // Map one-hot state to the output phase code
    function automatic logic [PhaseW-1:0] phase_code(input phase_t ph);
        logic [PhaseW-1:0] code;
        case (ph)
            ST_INIT:     code = PH_INIT;
            ST_SEARCH:   code = PH_SEARCH;
            ST_ACQUIRE:  code = PH_ACQUIRE;
            ST_ALIGN:    code = PH_ALIGN;
            ST_HOLD:     code = PH_HOLD;
            ST_DESCEND:  code = PH_DESCEND;
            ST_FINAL:    code = PH_FINAL;
            ST_LAND:     code = PH_LAND;
            ST_FAILSAFE: code = PH_FAILSAFE;
            default:     code = PH_INIT;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/landing_phase_sequencer.sv =====
// Top level of the landing phase sequencer: input register, step logic, result register.
//
// Usage: each transfer on the s_ channel carries one observation (failsafe
// code, x/y target error, altitude in mm, elapsed time in us). For each one
// the m_ channel returns exactly one transfer carrying the new phase code.
// Each observation passes through the input register, then through the phase
// logic into the result register. Throughput is one observation per cycle
// while m_tready is high; the phase, frame counter and hold timer update as
// an item moves from the input register to the result register, so
// consecutive items chain with no bubble.
// When m_tready is low the result register holds and the input register
// still takes one more item; after that s_tready drops until the result is
// taken. Configuration writes (cfg_we/cfg_index/cfg_wdata) take effect at the
// next clock edge and are meant to be made while the block is idle.
// Reset (aresetn low, synchronous) empties both registers, sets the phase to
// init, clears the counters and loads the register defaults.
module landing_phase_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Observation stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] failsafe_code, [17:2] offset_x, [33:18] offset_y,
    // [51:34] height_mm, [67:52] elapsed_us, [71:68] zero
    input  logic [lps_pkg::InDataW-1:0]    s_tdata,
    // Phase stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] phase, [7:4] zero
    output logic [lps_pkg::OutDataW-1:0]   m_tdata,
    // Configuration write port
    input  logic                           cfg_we,
    input  logic [lps_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [lps_pkg::CfgDataW-1:0]   cfg_wdata
);

    lps_pkg::cfg_t        cfg;
    lps_pkg::item_t       item_reg;
    lps_pkg::item_t       item_in;
    logic                 in_valid_reg;
    logic                 out_valid_reg;
    logic [lps_pkg::PhaseW-1:0] phase_out_reg;
    lps_pkg::seq_state_t  state_reg;
    lps_pkg::seq_state_t  state_next;
    logic                 advance;
    logic                 in_xfer;

    // Unpack input payload
    assign item_in.failsafe_code = s_tdata[1:0];
    assign item_in.offset_x      = $signed(s_tdata[17:2]);
    assign item_in.offset_y      = $signed(s_tdata[33:18]);
    assign item_in.height_mm     = $signed(s_tdata[51:34]);
    assign item_in.elapsed_us    = s_tdata[67:52];

    // Handshake: item moves on when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    lps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lps_step u_step (
        .item (item_reg),
        .cfg  (cfg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            item_reg <= item_in;
        end
    end

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase       <= lps_pkg::ST_INIT;
            state_reg.hold_timer  <= '0;
            state_reg.frame_count <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            phase_out_reg <= lps_pkg::phase_code(state_next.phase);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lps_pkg::OutDataW - lps_pkg::PhaseW){1'b0}}, phase_out_reg};

endmodule

// ===== rtl/lps_cfg.sv =====
// Configuration register file; the align radius is stored squared.
module lps_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [lps_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [lps_pkg::CfgDataW-1:0]   cfg_wdata,
    output lps_pkg::cfg_t                  cfg
);

    lps_pkg::cfg_t                       cfg_reg;
    logic [lps_pkg::RadiusW-1:0]         radius;

    assign radius = cfg_wdata[lps_pkg::RadiusW-1:0];

    // Register writes, radius squared on the way in
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.acquire_frames <= lps_pkg::CountW'(5);
            cfg_reg.radius_sq      <= lps_pkg::RadSqW'(400);
            cfg_reg.hold_time_us   <= lps_pkg::HoldW'(1000000);
            cfg_reg.descend_alt_mm <= lps_pkg::HeightW'(2000);
            cfg_reg.land_alt_mm    <= lps_pkg::HeightW'(300);
        end else if (cfg_we) begin
            case (cfg_index)
                lps_pkg::REG_ACQUIRE_FRAMES:
                    cfg_reg.acquire_frames <= cfg_wdata[lps_pkg::CountW-1:0];
                lps_pkg::REG_ALIGN_RADIUS:
                    cfg_reg.radius_sq <= radius * radius;
                lps_pkg::REG_HOLD_TIME:
                    cfg_reg.hold_time_us <= cfg_wdata[lps_pkg::HoldW-1:0];
                lps_pkg::REG_DESCEND_ALT:
                    cfg_reg.descend_alt_mm <= $signed(cfg_wdata[lps_pkg::HeightW-1:0]);
                lps_pkg::REG_LAND_ALT:
                    cfg_reg.land_alt_mm <= $signed(cfg_wdata[lps_pkg::HeightW-1:0]);
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/lps_step.sv =====
// Next-state logic of the phase sequencer for one observation.
module lps_step (
    input  lps_pkg::item_t       item,
    input  lps_pkg::cfg_t        cfg,
    input  lps_pkg::seq_state_t  cur,
    output lps_pkg::seq_state_t  nxt
);

    logic                              lost;
    logic                              crit;
    logic signed [2*lps_pkg::OffsetW-1:0] sq_x;
    logic signed [2*lps_pkg::OffsetW-1:0] sq_y;
    logic [lps_pkg::ErrSqW-1:0]        err_sq;
    logic [lps_pkg::ErrSqW-1:0]        rad_sq;
    logic [lps_pkg::ErrSqW-1:0]        rad_sq_x4;
    logic                              aligned;
    logic                              drifted;
    logic [lps_pkg::CountW-1:0]        cnt_base;
    logic [lps_pkg::CountW-1:0]        cnt_inc;
    logic [lps_pkg::TimerW-1:0]        tmr_base;
    logic [lps_pkg::TimerW:0]          tmr_sum;
    logic [lps_pkg::TimerW-1:0]        tmr_sat;

    assign lost = (item.failsafe_code == lps_pkg::FS_LOST) ||
                  (item.failsafe_code == lps_pkg::FS_STALE);
    assign crit = (item.failsafe_code == lps_pkg::FS_CRIT);

    // Squared error against squared radius, and four times it for drift
    assign sq_x      = item.offset_x * item.offset_x;
    assign sq_y      = item.offset_y * item.offset_y;
    assign err_sq    = {1'b0, sq_x[30:0]} + {1'b0, sq_y[30:0]};
    assign rad_sq    = {2'b00, cfg.radius_sq};
    assign rad_sq_x4 = {cfg.radius_sq, 2'b00};
    assign aligned   = err_sq < rad_sq;
    assign drifted   = err_sq >= rad_sq_x4;

    // Counters restart on a lost or stale frame (only reached here in land)
    assign cnt_base = lost ? '0 : cur.frame_count;
    assign cnt_inc  = (cnt_base == lps_pkg::CountMax) ? cnt_base : cnt_base + 1'b1;
    assign tmr_base = lost ? '0 : cur.hold_timer;
    assign tmr_sum  = {1'b0, tmr_base} + (lps_pkg::TimerW + 1)'(item.elapsed_us);
    assign tmr_sat  = tmr_sum[lps_pkg::TimerW] ? lps_pkg::TimerMax
                                               : tmr_sum[lps_pkg::TimerW-1:0];

    // Phase walk
    always_comb begin
        nxt = cur;
        if (crit) begin
            nxt.phase = lps_pkg::ST_FAILSAFE;
        end else if (lost && cur.phase != lps_pkg::ST_LAND) begin
            nxt.phase       = lps_pkg::ST_SEARCH;
            nxt.frame_count = '0;
            nxt.hold_timer  = '0;
        end else begin
            nxt.frame_count = cnt_inc;
            nxt.hold_timer  = tmr_base;
            case (cur.phase)
                lps_pkg::ST_INIT: begin
                    nxt.phase = lps_pkg::ST_SEARCH;
                end
                lps_pkg::ST_SEARCH: begin
                    if (cnt_inc >= cfg.acquire_frames)
                        nxt.phase = lps_pkg::ST_ACQUIRE;
                end
                lps_pkg::ST_ACQUIRE: begin
                    nxt.phase = lps_pkg::ST_ALIGN;
                end
                lps_pkg::ST_ALIGN: begin
                    if (aligned) begin
                        nxt.phase      = lps_pkg::ST_HOLD;
                        nxt.hold_timer = '0;
                    end
                end
                lps_pkg::ST_HOLD: begin
                    if (!aligned) begin
                        nxt.phase = lps_pkg::ST_ALIGN;
                    end else begin
                        nxt.hold_timer = tmr_sat;
                        if (tmr_sat >= lps_pkg::TimerW'(cfg.hold_time_us))
                            nxt.phase = lps_pkg::ST_DESCEND;
                    end
                end
                lps_pkg::ST_DESCEND: begin
                    if (drifted)
                        nxt.phase = lps_pkg::ST_ALIGN;
                    else if (item.height_mm < cfg.descend_alt_mm)
                        nxt.phase = lps_pkg::ST_FINAL;
                end
                lps_pkg::ST_FINAL: begin
                    if (item.height_mm < cfg.land_alt_mm)
                        nxt.phase = lps_pkg::ST_LAND;
                end
                default: ;
            endcase
        end
    end

endmodule
